### rtl/mer_pkg.sv
// shared types and constants for the midpoint ellipse rasterizer
`timescale 1ns / 1ps

package mer_pkg;

    localparam int COLOR_W    = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int RUN_W      = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_COLOR  = 2'd2;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // final run of the eight: (+x,-y) region 2
    localparam logic [RUN_W-1:0] LAST_RUN = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_INIT,
        ST_SET,
        ST_TERMS,
        ST_UPDATE,
        ST_USQ,
        ST_LHS,
        ST_CHECK,
        ST_EMIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        DP_NONE,
        DP_LOAD,
        DP_SQUARE,
        DP_INIT,
        DP_SET,
        DP_TERMS,
        DP_UPDATE,
        DP_USQ,
        DP_LHS,
        DP_CHECK
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic run_end;
        logic last_run;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/mer_ctrl.sv
// sequencing state machine for the ellipse rasterizer
`timescale 1ns / 1ps

module mer_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    output mer_pkg::dp_cmd_t    dp_cmd,
    input  mer_pkg::dp_status_t dp_status
);

    mer_pkg::ctrl_state_t state_reg, state_next;
    logic busy_reg, busy_next;
    logic start_reg, start_next;
    logic accept;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mer_pkg::ST_IDLE;
            busy_reg  <= 1'b0;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            start_reg <= start_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        busy_next  = busy_reg;
        start_next = start_reg;
        unique case (state_reg)
            mer_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == mer_pkg::CMD_START) begin
                        state_next = mer_pkg::ST_SQUARE;
                        start_next = 1'b1;
                        busy_next  = 1'b1;
                    end else if (busy_reg) begin
                        state_next = mer_pkg::ST_SQUARE;
                        start_next = 1'b0;
                    end
                end
            end
            mer_pkg::ST_SQUARE: begin
                state_next = start_reg ? mer_pkg::ST_INIT : mer_pkg::ST_TERMS;
            end
            mer_pkg::ST_INIT:   state_next = mer_pkg::ST_SET;
            mer_pkg::ST_SET:    state_next = mer_pkg::ST_IDLE;
            mer_pkg::ST_TERMS:  state_next = mer_pkg::ST_UPDATE;
            mer_pkg::ST_UPDATE: state_next = mer_pkg::ST_USQ;
            mer_pkg::ST_USQ:    state_next = mer_pkg::ST_LHS;
            mer_pkg::ST_LHS:    state_next = mer_pkg::ST_CHECK;
            mer_pkg::ST_CHECK: begin
                if (dp_status.run_end && dp_status.last_run) begin
                    busy_next = 1'b0;
                end
                state_next = dp_status.out_free ? mer_pkg::ST_IDLE : mer_pkg::ST_EMIT;
            end
            mer_pkg::ST_EMIT: begin
                if (dp_status.out_free) begin
                    state_next = mer_pkg::ST_IDLE;
                end
            end
            default: state_next = mer_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        dp_cmd.op   = mer_pkg::DP_NONE;
        dp_cmd.emit = 1'b0;
        unique case (state_reg)
            mer_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                dp_cmd.op = accept ? mer_pkg::DP_LOAD : mer_pkg::DP_NONE;
            end
            mer_pkg::ST_SQUARE: dp_cmd.op = mer_pkg::DP_SQUARE;
            mer_pkg::ST_INIT:   dp_cmd.op = mer_pkg::DP_INIT;
            mer_pkg::ST_SET:    dp_cmd.op = mer_pkg::DP_SET;
            mer_pkg::ST_TERMS:  dp_cmd.op = mer_pkg::DP_TERMS;
            mer_pkg::ST_UPDATE: dp_cmd.op = mer_pkg::DP_UPDATE;
            mer_pkg::ST_USQ:    dp_cmd.op = mer_pkg::DP_USQ;
            mer_pkg::ST_LHS:    dp_cmd.op = mer_pkg::DP_LHS;
            mer_pkg::ST_CHECK: begin
                dp_cmd.op   = mer_pkg::DP_CHECK;
                dp_cmd.emit = dp_status.out_free;
            end
            mer_pkg::ST_EMIT: begin
                dp_cmd.emit = dp_status.out_free;
            end
            default: dp_cmd.op = mer_pkg::DP_NONE;
        endcase
    end

endmodule

### rtl/mer_datapath.sv
// config registers, two shared multipliers, run state and output register
`timescale 1ns / 1ps

module mer_datapath #(
    parameter int AXIS_BITS  = 10,
    parameter int COORD_BITS = 11,
    parameter int IN_W       = 24,
    parameter int OUT_W      = 56
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mer_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [IN_W-1:0]                   s_tdata,
    input  logic                              s_tuser,
    input  mer_pkg::dp_cmd_t                  dp_cmd,
    output mer_pkg::dp_status_t               dp_status,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [OUT_W-1:0]                  m_tdata,
    output logic                              m_tlast
);

    localparam int A      = AXIS_BITS;
    localparam int OFF_W  = AXIS_BITS + 2;
    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int MUL_W  = 2 * AXIS_BITS + 4;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DEC_W  = PROD_W;
    localparam int PIX_W  = COORD_BITS + 2;
    localparam int SUM_W  = ((COORD_BITS + 1 > OFF_W) ? COORD_BITS + 1 : OFF_W) + 1;

    localparam logic [A-1:0]              AXIS_ONE = A'(1);
    localparam logic signed [OFF_W-1:0]   OFF_ONE  = OFF_W'(1);
    localparam logic signed [MUL_W-1:0]   MUL_TWO  = MUL_W'(2);
    localparam logic signed [MUL_W-1:0]   MUL_THREE = MUL_W'(3);
    localparam logic [mer_pkg::RUN_W-1:0] RUN_ONE  = mer_pkg::RUN_W'(1);
    localparam logic [mer_pkg::RUN_W-1:0] RUN_ZERO = '0;

    // configuration
    logic [A-1:0]                 semi_axis_x_reg;
    logic [A-1:0]                 semi_axis_y_reg;
    logic [mer_pkg::COLOR_W-1:0]  draw_color_reg;

    // run state
    logic [mer_pkg::RUN_W-1:0]    run_reg;
    logic signed [OFF_W-1:0]      off_x_reg;
    logic signed [OFF_W-1:0]      off_y_reg;
    logic signed [DEC_W-1:0]      dec_reg;
    logic [COORD_BITS-1:0]        held_cx_reg;
    logic [COORD_BITS-1:0]        held_cy_reg;

    // arithmetic staging
    logic [SQ_W-1:0]              a2_reg;
    logic [SQ_W-1:0]              b2_reg;
    logic [SQ_W:0]                sum_reg;
    logic signed [PROD_W-1:0]     p0_reg;
    logic signed [PROD_W-1:0]     p1_reg;
    logic signed [PROD_W-1:0]     lim_reg;

    // pixel of the current transaction and output stage
    logic [PIX_W-1:0]             pix_x_reg;
    logic [PIX_W-1:0]             pix_y_reg;
    logic                         last_reg;
    logic                         m_tvalid_reg;
    logic [OUT_W-1:0]             m_tdata_reg;
    logic                         m_tlast_reg;

    logic [A-1:0]             a_eff, b_eff;
    logic signed [MUL_W-1:0]  a_m, b_m, a2_m, b2_m, sum_m, uu_m;
    logic signed [MUL_W-1:0]  u_ext, v_ext, two_u3, two_m2v;
    logic signed [MUL_W-1:0]  m0_a, m0_b, m1_a, m1_b;
    logic signed [PROD_W-1:0] p0_next, p1_next;
    logic                     region1, neg_x, neg_y;
    logic signed [OFF_W-1:0]  mag_x, mag_y, u_cur, v_cur;
    logic                     dec_pos;
    logic signed [OFF_W-1:0]  u_new, v_new, new_mx, new_my, new_off_x, new_off_y;
    logic signed [DEC_W-1:0]  dec_upd;
    logic                     nr_region1;
    logic                     run_ok, last_now, out_free;
    logic [mer_pkg::RUN_W-1:0] tgt_run;
    logic                     tgt_region1, tgt_neg_x, tgt_neg_y;
    logic signed [OFF_W-1:0]  a_off, b_off, init_off_x, init_off_y;
    logic signed [DEC_W-1:0]  a2_d, b2_d, init_dec;
    logic signed [SUM_W-1:0]  pix_x_sum, pix_y_sum;

    assign a_eff = (semi_axis_x_reg == '0) ? AXIS_ONE : semi_axis_x_reg;
    assign b_eff = (semi_axis_y_reg == '0) ? AXIS_ONE : semi_axis_y_reg;

    assign a_m   = $signed({{(MUL_W-A){1'b0}}, a_eff});
    assign b_m   = $signed({{(MUL_W-A){1'b0}}, b_eff});
    assign a2_m  = $signed({{(MUL_W-SQ_W){1'b0}}, a2_reg});
    assign b2_m  = $signed({{(MUL_W-SQ_W-1){1'b0}}, sum_reg});
    assign sum_m = b2_m;
    assign uu_m  = $signed(p0_reg[MUL_W-1:0]);

    // run r: bit 0 picks region 2, quadrant q = r[2:1] sets the signs
    assign region1 = !run_reg[0];
    assign neg_x   = run_reg[2] ^ run_reg[1];
    assign neg_y   = run_reg[2];
    assign mag_x   = neg_x ? -off_x_reg : off_x_reg;
    assign mag_y   = neg_y ? -off_y_reg : off_y_reg;
    assign u_cur   = region1 ? mag_x : mag_y;
    assign v_cur   = region1 ? mag_y : mag_x;

    assign u_ext   = $signed({{(MUL_W-OFF_W){u_cur[OFF_W-1]}}, u_cur});
    assign v_ext   = $signed({{(MUL_W-OFF_W){v_cur[OFF_W-1]}}, v_cur});
    assign two_u3  = (u_ext <<< 1) + MUL_THREE;
    assign two_m2v = MUL_TWO - (v_ext <<< 1);

    // the run after this one has the other region, except for the start
    assign nr_region1 = (dp_cmd.op == mer_pkg::DP_INIT) ? 1'b1 : run_reg[0];

    logic signed [MUL_W-1:0] sq_same_m, sq_other_m;
    assign sq_same_m  = region1 ? $signed({{(MUL_W-SQ_W){1'b0}}, b2_reg}) : a2_m;
    assign sq_other_m = region1 ? a2_m : $signed({{(MUL_W-SQ_W){1'b0}}, b2_reg});

    always_comb begin
        m0_a = '0;
        m0_b = '0;
        m1_a = '0;
        m1_b = '0;
        case (dp_cmd.op) inside
            mer_pkg::DP_SQUARE: begin
                m0_a = a_m;
                m0_b = a_m;
                m1_a = b_m;
                m1_b = b_m;
            end
            mer_pkg::DP_TERMS: begin
                m0_a = two_u3;
                m0_b = sq_same_m;
                m1_a = two_m2v;
                m1_b = sq_other_m;
            end
            mer_pkg::DP_USQ: begin
                m0_a = u_ext;
                m0_b = u_ext;
                // region bound: a^4 for region 1, b^4 for region 2
                m1_a = sq_other_m;
                m1_b = sq_other_m;
            end
            mer_pkg::DP_LHS, mer_pkg::DP_INIT: begin
                m0_a = uu_m;
                m0_b = sum_m;
                m1_a = nr_region1 ? b_m : a_m;
                m1_b = nr_region1 ? a2_m : $signed({{(MUL_W-SQ_W){1'b0}}, b2_reg});
            end
            default: begin
                m0_a = '0;
            end
        endcase
    end

    assign p0_next = m0_a * m0_b;
    assign p1_next = m1_a * m1_b;

    // decision update and one step along the run
    assign dec_pos   = dec_reg > $signed({DEC_W{1'b0}});
    assign dec_upd   = dec_reg + (p0_reg <<< 2) + (dec_pos ? (p1_reg <<< 2) : '0);
    assign u_new     = u_cur + OFF_ONE;
    assign v_new     = dec_pos ? (v_cur - OFF_ONE) : v_cur;
    assign new_mx    = region1 ? u_new : v_new;
    assign new_my    = region1 ? v_new : u_new;
    assign new_off_x = neg_x ? -new_mx : new_mx;
    assign new_off_y = neg_y ? -new_my : new_my;

    // region-2 test is strict for the upper quadrants only
    always_comb begin
        if (!region1 && !run_reg[2]) begin
            run_ok = p0_reg < lim_reg;
        end else begin
            run_ok = p0_reg <= lim_reg;
        end
    end
    assign last_now = !run_ok && (run_reg == mer_pkg::LAST_RUN);

    // start state of the target run
    assign tgt_run     = (dp_cmd.op == mer_pkg::DP_SET) ? RUN_ZERO : run_reg + RUN_ONE;
    assign tgt_region1 = !tgt_run[0];
    assign tgt_neg_x   = tgt_run[2] ^ tgt_run[1];
    assign tgt_neg_y   = tgt_run[2];
    assign a_off       = $signed({{(OFF_W-A){1'b0}}, a_eff});
    assign b_off       = $signed({{(OFF_W-A){1'b0}}, b_eff});
    assign init_off_x  = tgt_region1 ? '0 : (tgt_neg_x ? -a_off : a_off);
    assign init_off_y  = tgt_region1 ? (tgt_neg_y ? -b_off : b_off) : '0;
    assign a2_d        = $signed({{(DEC_W-SQ_W){1'b0}}, a2_reg});
    assign b2_d        = $signed({{(DEC_W-SQ_W){1'b0}}, b2_reg});
    assign init_dec    = tgt_region1 ? ((b2_d <<< 2) - (p1_reg <<< 2) + a2_d)
                                     : ((a2_d <<< 2) - (p1_reg <<< 2) + b2_d);

    assign pix_x_sum = $signed({{(SUM_W-COORD_BITS){1'b0}}, held_cx_reg})
                     + $signed({{(SUM_W-OFF_W){off_x_reg[OFF_W-1]}}, off_x_reg});
    assign pix_y_sum = $signed({{(SUM_W-COORD_BITS){1'b0}}, held_cy_reg})
                     + $signed({{(SUM_W-OFF_W){off_y_reg[OFF_W-1]}}, off_y_reg});

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            semi_axis_x_reg <= AXIS_ONE;
            semi_axis_y_reg <= AXIS_ONE;
            draw_color_reg  <= '1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mer_pkg::CFG_SEMI_AXIS_X: semi_axis_x_reg <= cfg_wdata[A-1:0];
                mer_pkg::CFG_SEMI_AXIS_Y: semi_axis_y_reg <= cfg_wdata[A-1:0];
                mer_pkg::CFG_DRAW_COLOR:  draw_color_reg  <= cfg_wdata[mer_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg     <= '0;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            dec_reg     <= '0;
            held_cx_reg <= '0;
            held_cy_reg <= '0;
        end else begin
            case (dp_cmd.op)
                mer_pkg::DP_LOAD: begin
                    if (s_tuser == mer_pkg::CMD_START) begin
                        held_cx_reg <= s_tdata[COORD_BITS-1:0];
                        held_cy_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
                    end
                end
                mer_pkg::DP_UPDATE: begin
                    dec_reg   <= dec_upd;
                    off_x_reg <= new_off_x;
                    off_y_reg <= new_off_y;
                end
                mer_pkg::DP_SET: begin
                    run_reg   <= tgt_run;
                    off_x_reg <= init_off_x;
                    off_y_reg <= init_off_y;
                    dec_reg   <= init_dec;
                end
                mer_pkg::DP_CHECK: begin
                    if (!run_ok) begin
                        if (run_reg == mer_pkg::LAST_RUN) begin
                            run_reg <= RUN_ZERO;
                        end else begin
                            run_reg   <= tgt_run;
                            off_x_reg <= init_off_x;
                            off_y_reg <= init_off_y;
                            dec_reg   <= init_dec;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        p0_reg <= p0_next;
        p1_reg <= p1_next;
        if (dp_cmd.op == mer_pkg::DP_SQUARE) begin
            a2_reg <= p0_next[SQ_W-1:0];
            b2_reg <= p1_next[SQ_W-1:0];
        end
        if (dp_cmd.op == mer_pkg::DP_TERMS) begin
            sum_reg <= {1'b0, a2_reg} + {1'b0, b2_reg};
        end
        if (dp_cmd.op == mer_pkg::DP_LHS) begin
            lim_reg <= p1_reg;
        end
        if (dp_cmd.op == mer_pkg::DP_LOAD && s_tuser == mer_pkg::CMD_STEP) begin
            pix_x_reg <= pix_x_sum[PIX_W-1:0];
            pix_y_reg <= pix_y_sum[PIX_W-1:0];
        end
        if (dp_cmd.op == mer_pkg::DP_CHECK) begin
            last_reg <= last_now;
        end
    end

    // output register, loaded only when empty or being drained
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (dp_cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.emit) begin
            m_tdata_reg <= OUT_W'({draw_color_reg, pix_y_reg, pix_x_reg});
            m_tlast_reg <= (dp_cmd.op == mer_pkg::DP_CHECK) ? last_now : last_reg;
        end
    end

    assign dp_status.run_end  = !run_ok;
    assign dp_status.last_run = (run_reg == mer_pkg::LAST_RUN);
    assign dp_status.out_free = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### rtl/midpoint_ellipse_rasterizer.sv
// top level of the midpoint ellipse rasterizer
//
//  channel   direction  transaction contents
//  s_        in         tuser: cmd (start/step); tdata: center_x, center_y
//  m_        out        tdata: pixel_x, pixel_y, pixel_color; tlast: last_pixel
//  cfg_      in         write of semi_axis_x, semi_axis_y or draw_color
//
// a start transaction occupies the block through its square, init and set states, a step that yields a pixel
// through its own: squares, update terms, decision update, squared offset, boundary
// product and check run one after another on two shared multipliers
// a step while no ellipse is active is taken in the idle state and yields nothing
// a result waits in the output register; a stalled m_ side holds the next step
// in its emit state until the register drains. reset is synchronous, no clearing
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer #(
    parameter int AXIS_BITS  = 10,
    parameter int COORD_BITS = 11
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [mer_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mer_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // center_x, center_y, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_tdata,
    // cmd
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    output logic [((2*COORD_BITS+4+mer_pkg::COLOR_W+7)/8)*8-1:0] m_tdata,
    output logic                               m_tlast
);

    localparam int IN_W  = ((2*COORD_BITS+7)/8)*8;
    localparam int OUT_W = ((2*COORD_BITS+4+mer_pkg::COLOR_W+7)/8)*8;

    mer_pkg::dp_cmd_t    dp_cmd;
    mer_pkg::dp_status_t dp_status;

    mer_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tuser   (s_tuser),
        .s_tready  (s_tready),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status)
    );

    mer_datapath #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS),
        .IN_W       (IN_W),
        .OUT_W      (OUT_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

### rtl/mer_checker.sv
// port-level checks for the ellipse rasterizer, bound to the top level
`timescale 1ns / 1ps

module mer_checker #(
    parameter int OUT_W = 56
) (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    // output register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // a start transaction blocks the input and never produces a pixel next cycle
    a_start_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == mer_pkg::CMD_START)
            |=> !s_tready && !$rose(m_tvalid))
        else $error("start transaction not followed by setup cycles");

    // a new pixel only appears while a step is being worked on
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("pixel emitted while input side was idle");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled pixel transaction changed");

endmodule

bind midpoint_ellipse_rasterizer mer_checker #(.OUT_W(OUT_W)) u_mer_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/mer_checker.sv
// pixel predictor and scoreboard for the midpoint ellipse rasterizer
`timescale 1ns / 1ps

module mer_scoreboard #(
    parameter int AXIS_BITS  = 10,
    parameter int COORD_BITS = 11
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              cfg_wr_en,
    input  logic [mer_pkg::CFG_IDX_W-1:0]                     cfg_index,
    input  logic [mer_pkg::CFG_DATA_W-1:0]                    cfg_wdata,
    input  logic                                              s_tvalid,
    input  logic                                              s_tready,
    // center_x, center_y, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]                 s_tdata,
    // cmd
    input  logic                                              s_tuser,
    input  logic                                              m_tvalid,
    input  logic                                              m_tready,
    // pixel_x, pixel_y, pixel_color, zero pad
    input  logic [((2*COORD_BITS+4+mer_pkg::COLOR_W+7)/8)*8-1:0] m_tdata,
    input  logic                                              m_tlast,
    output int                                                mismatch_count,
    output int                                                pixels_pending
);

    localparam int PIX_W   = COORD_BITS + 2;
    localparam int COLOR_W = mer_pkg::COLOR_W;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    pixel_t pixel_queue[$];

    logic [AXIS_BITS-1:0] axis_x_reg;
    logic [AXIS_BITS-1:0] axis_y_reg;
    logic [COLOR_W-1:0]   color_reg;
    logic                 drawing;
    int                   run_idx;
    longint               off_x;
    longint               off_y;
    longint               decision;
    longint               cen_x;
    longint               cen_y;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // a zero axis register counts as one
    function automatic longint semi_a();
        return (axis_x_reg == '0) ? 64'sd1 : longint'(axis_x_reg);
    endfunction

    function automatic longint semi_b();
        return (axis_y_reg == '0) ? 64'sd1 : longint'(axis_y_reg);
    endfunction

    // quadrant order: (+,+), (-,+), (-,-), (+,-), two runs each
    function automatic bit x_negative(input int run);
        return (run[2:1] == 2'd1) || (run[2:1] == 2'd2);
    endfunction

    function automatic bit y_negative(input int run);
        return run[2];
    endfunction

    function automatic bit run_continues(input int run, input longint u);
        longint a2, b2, lhs;
        a2  = semi_a() * semi_a();
        b2  = semi_b() * semi_b();
        lhs = u * u * (a2 + b2);
        if (!run[0])
            return lhs <= a2 * a2;
        if (run < 4)
            return lhs < b2 * b2;
        return lhs <= b2 * b2;
    endfunction

    function automatic void enter_run(input int run);
        longint a, b, a2, b2;
        a  = semi_a();
        b  = semi_b();
        a2 = a * a;
        b2 = b * b;
        if (!run[0]) begin
            off_x    = 0;
            off_y    = y_negative(run) ? -b : b;
            decision = 4 * b2 - 4 * b * a2 + a2;
        end else begin
            off_x    = x_negative(run) ? -a : a;
            off_y    = 0;
            decision = 4 * a2 - 4 * a * b2 + b2;
        end
    endfunction

    // emits the current pixel and advances the midpoint walk
    function automatic bit trace_pixel(output pixel_t pix);
        longint sx, sy, u, v, p, q, px, py;
        int     r;
        pix = '0;
        if (!drawing)
            return 1'b0;
        px = cen_x + off_x;
        py = cen_y + off_y;
        r  = run_idx;
        sx = x_negative(r) ? -1 : 1;
        sy = y_negative(r) ? -1 : 1;
        if (!r[0]) begin
            u = sx * off_x;
            v = sy * off_y;
            p = semi_b() * semi_b();
            q = semi_a() * semi_a();
        end else begin
            u = sy * off_y;
            v = sx * off_x;
            p = semi_a() * semi_a();
            q = semi_b() * semi_b();
        end
        if (decision <= 0) begin
            decision += 4 * (2 * u + 3) * p;
        end else begin
            decision += 4 * (2 * u + 3) * p + 4 * (2 - 2 * v) * q;
            v--;
        end
        u++;
        if (!r[0]) begin
            off_x = sx * u;
            off_y = sy * v;
        end else begin
            off_x = sx * v;
            off_y = sy * u;
        end
        pix.x     = px[PIX_W-1:0];
        pix.y     = py[PIX_W-1:0];
        pix.color = color_reg;
        pix.last  = 1'b0;
        if (!run_continues(r, u)) begin
            r++;
            // skip runs that are empty from their first pixel
            while (r < 8) begin
                enter_run(r);
                if (run_continues(r, 0))
                    break;
                r++;
            end
            if (r >= 8) begin
                drawing  = 1'b0;
                r        = 0;
                pix.last = 1'b1;
            end
            run_idx = r;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        pixel_t want;
        pixel_t next_pix;
        if (!aresetn) begin
            axis_x_reg = 1;
            axis_y_reg = 1;
            color_reg  = '1;
            drawing    = 1'b0;
            run_idx    = 0;
            off_x      = 0;
            off_y      = 0;
            decision   = 0;
            cen_x      = 0;
            cen_y      = 0;
            pixel_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mer_pkg::CFG_SEMI_AXIS_X: axis_x_reg = cfg_wdata[AXIS_BITS-1:0];
                    mer_pkg::CFG_SEMI_AXIS_Y: axis_y_reg = cfg_wdata[AXIS_BITS-1:0];
                    mer_pkg::CFG_DRAW_COLOR:  color_reg  = cfg_wdata[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (pixel_queue.size() == 0) begin
                    report_mismatch("unexpected pixel", 64'(m_tdata[2*PIX_W-1:0]), '0);
                end else begin
                    want = pixel_queue.pop_front();
                    if (m_tdata[PIX_W-1:0] !== want.x)
                        report_mismatch("pixel_x", 64'(m_tdata[PIX_W-1:0]), 64'(want.x));
                    if (m_tdata[2*PIX_W-1:PIX_W] !== want.y)
                        report_mismatch("pixel_y", 64'(m_tdata[2*PIX_W-1:PIX_W]),
                                        64'(want.y));
                    if (m_tdata[2*PIX_W+COLOR_W-1:2*PIX_W] !== want.color)
                        report_mismatch("pixel_color",
                                        64'(m_tdata[2*PIX_W+COLOR_W-1:2*PIX_W]),
                                        64'(want.color));
                    if (m_tlast !== want.last)
                        report_mismatch("last_pixel", 64'(m_tlast), 64'(want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == mer_pkg::CMD_START) begin
                    cen_x   = longint'(s_tdata[COORD_BITS-1:0]);
                    cen_y   = longint'(s_tdata[2*COORD_BITS-1:COORD_BITS]);
                    drawing = 1'b1;
                    run_idx = 0;
                    enter_run(0);
                end else if (trace_pixel(next_pix)) begin
                    pixel_queue.push_back(next_pix);
                end
            end
        end
        pixels_pending <= pixel_queue.size();
    end

endmodule

### bench/tb.sv
// stimulus, clock, reset and verdict for the midpoint ellipse rasterizer
`timescale 1ns / 1ps

module tb;

    localparam int AXIS_BITS     = 10;
    localparam int COORD_BITS    = 11;
    localparam int CFG_IDX_W     = mer_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = mer_pkg::CFG_DATA_W;
    localparam int IN_W          = ((2*COORD_BITS+7)/8)*8;
    localparam int OUT_W         = ((2*COORD_BITS+4+mer_pkg::COLOR_W+7)/8)*8;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int ITEM_TARGET   = 550;
    localparam int SMALL_AXIS    = 12;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;   // center_x, center_y, zero pad
    logic                  s_tuser;   // cmd
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_W-1:0]      m_tdata;   // pixel_x, pixel_y, pixel_color, zero pad
    logic                  m_tlast;

    int   mismatch_count;
    int   pixels_pending;
    int   items_sent   = 0;
    int   last_count   = 0;
    int   stall_cycles = 0;
    int   tx_idle_pct  = 6;
    int   rx_idle_pct  = 64;
    int   hold_left    = 0;
    logic hold_kick    = 1'b0;

    midpoint_ellipse_rasterizer #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    mer_scoreboard #(
        .AXIS_BITS  (AXIS_BITS),
        .COORD_BITS (COORD_BITS)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pixels_pending (pixels_pending)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // receiver: random stalls, or a long hold-off once kicked
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_kick) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (m_tvalid && m_tready && m_tlast)
            last_count <= last_count + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic cmd, input logic [COORD_BITS-1:0] cx,
                             input logic [COORD_BITS-1:0] cy);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_W-2*COORD_BITS){1'b0}}, cy, cx};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // only with nothing in flight; a start or an idle step leaves no result to wait on
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (pixels_pending != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // start at the centre, then step until the flagged pixel or max_steps
    task automatic draw(input logic [COORD_BITS-1:0] cx, input logic [COORD_BITS-1:0] cy,
                        input int max_steps, input int change_at);
        int base;
        int n;
        base = last_count;
        send_item(mer_pkg::CMD_START, cx, cy);
        n = 0;
        while (last_count == base && n < max_steps) begin
            if (n == change_at) begin
                write_reg(mer_pkg::CFG_DRAW_COLOR, CFG_DATA_W'($urandom));
                if ($urandom_range(1))
                    write_reg(mer_pkg::CFG_SEMI_AXIS_Y,
                              CFG_DATA_W'($urandom_range(1, SMALL_AXIS)));
            end
            send_item(mer_pkg::CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom));
            n++;
        end
    endtask

    initial begin : stimulus
        int ph;
        int phase_end;
        int pick;
        int a_len;
        int b_len;
        int bound;
        int change_at;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = mer_pkg::CMD_STEP;
        s_tdata   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = mer_pkg::CFG_SEMI_AXIS_X;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: idle step, smallest ellipse from reset values at the origin
        send_item(mer_pkg::CMD_STEP, '1, '1);
        draw('0, '0, 16, -1);
        // zero axis via masked high bits, widest b, black, unused index
        write_reg(mer_pkg::CFG_SEMI_AXIS_X, 24'hFFFC00);
        write_reg(mer_pkg::CFG_SEMI_AXIS_Y, 24'h0003FF);
        write_reg(mer_pkg::CFG_DRAW_COLOR, '0);
        write_reg(CFG_UNUSED, '1);
        draw('1, '1, 4, -1);
        // restart while busy, then change every register mid ellipse
        draw(11'd1000, 11'd3, 3, -1);
        write_reg(mer_pkg::CFG_SEMI_AXIS_X, 24'h0003FF);
        write_reg(mer_pkg::CFG_SEMI_AXIS_Y, 24'd2);
        write_reg(mer_pkg::CFG_DRAW_COLOR, 24'hA5A5A5);
        repeat (3) send_item(mer_pkg::CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom));

        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct <= 64;
                end
                1: begin
                    tx_idle_pct = 64;
                    rx_idle_pct <= 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            if (ph == 2) begin
                // long hold-off while a big ellipse keeps the input busy
                write_reg(mer_pkg::CFG_SEMI_AXIS_X, 24'd300);
                write_reg(mer_pkg::CFG_SEMI_AXIS_Y, 24'd200);
                hold_kick <= 1'b1;
                @(negedge aclk);
                hold_kick <= 1'b0;
                draw(COORD_BITS'($urandom), COORD_BITS'($urandom), 40, -1);
            end
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (3 - ph);
            while (items_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    repeat ($urandom_range(1, 4))
                        send_item(1'($urandom_range(1)), COORD_BITS'($urandom),
                                  COORD_BITS'($urandom));
                end else begin
                    if (pick < 80) begin
                        a_len = $urandom_range(1, SMALL_AXIS);
                        b_len = $urandom_range(1, SMALL_AXIS);
                    end else if (pick < 95) begin
                        a_len = $urandom_range(SMALL_AXIS + 1, 60);
                        b_len = $urandom_range(1, 60);
                    end else begin
                        a_len = $urandom_range(500, 1023);
                        b_len = $urandom_range(500, 1023);
                    end
                    if ($urandom_range(7) == 0)
                        a_len = 0;
                    if ($urandom_range(7) == 0)
                        b_len = 0;
                    // junk above the axis width is dropped by the block
                    write_reg(mer_pkg::CFG_SEMI_AXIS_X,
                              CFG_DATA_W'(($urandom & 24'hFFFC00) | a_len));
                    write_reg(mer_pkg::CFG_SEMI_AXIS_Y,
                              CFG_DATA_W'(($urandom & 24'hFFFC00) | b_len));
                    if ($urandom_range(3) == 0)
                        write_reg(mer_pkg::CFG_DRAW_COLOR, CFG_DATA_W'($urandom));
                    bound = 4 * (a_len + b_len) + 40;
                    if (pick >= 95)
                        bound = 30;
                    if ($urandom_range(9) == 0)
                        bound = $urandom_range(1, 20);
                    change_at = ($urandom_range(6) == 0) ? $urandom_range(1, bound) : -1;
                    draw(COORD_BITS'($urandom), COORD_BITS'($urandom), bound, change_at);
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pixels_pending != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && pixels_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/mer_pkg.sv
rtl/mer_ctrl.sv
rtl/mer_datapath.sv
rtl/midpoint_ellipse_rasterizer.sv
rtl/mer_checker.sv
bench/mer_checker.sv
bench/tb.sv
